FILE: sv/mcra_pkg.sv
// shared constants, types and register codes of the adc running average block
`timescale 1ns / 1ps

package mcra_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int SAMPLE_BITS  = 12;
  localparam int LENGTH_BITS  = 8;

  localparam int CH_BITS     = 3;
  localparam int USED_BITS   = 4;
  localparam int SLOT_BITS   = 8;
  localparam int MASK_BITS   = 8;
  localparam int PERIOD_BITS = 16;
  localparam int CFG_BITS    = 64;
  localparam int ADDR_BITS   = 2;

  // widest accumulated sum: sample plus (count - 1) quotients plus remainder
  localparam int ACC_BITS  = SAMPLE_BITS + LENGTH_BITS;
  localparam int STEP_BITS = $clog2(ACC_BITS + 1);

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX  = {SAMPLE_BITS{1'b1}};
  localparam logic [SLOT_BITS-1:0]   LENGTH_MASK = SLOT_BITS'((1 << LENGTH_BITS) - 1);

  typedef enum logic [ADDR_BITS-1:0] {
    CFG_CHANNELS_USED  = 2'd0,
    CFG_FILTER_LENGTHS = 2'd1,
    CFG_REPORT_MASK    = 2'd2,
    CFG_REPORT_PERIOD  = 2'd3
  } cfg_reg_t;

  // per-channel record kept in the state memory
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] latest;
    logic [SAMPLE_BITS-1:0] quot;
    logic [LENGTH_BITS-1:0] rem;
    logic [LENGTH_BITS-1:0] cnt;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

endpackage

FILE: sv/mcra_if.sv
// valid/ready channel interfaces for samples and report transactions
`timescale 1ns / 1ps

interface mcra_in_if;
  logic                             valid;
  logic                             ready;
  logic [mcra_pkg::SAMPLE_BITS-1:0] sample;
  logic                             sample_present;

  modport source (output valid, output sample, output sample_present, input ready);
  modport sink   (input valid, input sample, input sample_present, output ready);
endinterface

interface mcra_out_if;
  logic                             valid;
  logic                             ready;
  logic [mcra_pkg::CH_BITS-1:0]     channel;
  logic [mcra_pkg::SAMPLE_BITS-1:0] value;
  logic                             last;

  modport source (output valid, output channel, output value, output last, input ready);
  modport sink   (input valid, input channel, input value, input last, output ready);
endinterface

FILE: sv/multichannel_adc_running_average.sv
// round-robin multichannel adc running average with periodic value reports
`timescale 1ns / 1ps
// an averaged sample passes read, multiply, sum, 20 divide steps of the serial restoring divider,
//   write back and advance; a raw sample goes from read to write back and advance, an empty read to advance
// a new sample is taken only once the last one and any report run are done; a report run scans
//   the active channels in ascending order, loading each enabled one (sink stalls hold the load),
//   and ends after the last enabled one or, with none enabled, after scanning every active channel
// synchronous reset clears config to defaults, pointer, round counter, output and valid bits

module multichannel_adc_running_average (
  input  logic                                 clk,
  input  logic                                 rst_n,
  mcra_in_if.sink                              in_chan,
  mcra_out_if.source                           out_chan,
  input  logic                                 cfg_we,
  input  logic [mcra_pkg::ADDR_BITS-1:0]       cfg_addr,
  input  logic [mcra_pkg::CFG_BITS-1:0]        cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a sample transaction
    S_READ,   // channel record arrives from memory
    S_ADD,    // product registered, form the sum
    S_DIV,    // one quotient bit per cycle
    S_WB,     // round, saturate, write record back
    S_ADV,    // step pointer and round counter
    S_SCAN,   // report: pick next enabled channel
    S_LOAD    // report: move value into output register
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [mcra_pkg::USED_BITS-1:0]   channels_used_r, channels_used_nxt;
  logic [mcra_pkg::CFG_BITS-1:0]    filter_lengths_r, filter_lengths_nxt;
  logic [mcra_pkg::MASK_BITS-1:0]   report_mask_r, report_mask_nxt;
  logic [mcra_pkg::PERIOD_BITS-1:0] report_period_r, report_period_nxt;

  // control state
  logic [mcra_pkg::CH_BITS-1:0]     ptr_r, ptr_nxt;
  logic [mcra_pkg::PERIOD_BITS-1:0] round_r, round_nxt;
  logic [mcra_pkg::NUM_CHANNELS-1:0] valid_r, valid_nxt;
  logic [mcra_pkg::USED_BITS-1:0]   rep_ch_r, rep_ch_nxt;

  // output register
  logic                             out_valid_r, out_valid_nxt;
  logic [mcra_pkg::CH_BITS-1:0]     out_channel_r, out_channel_nxt;
  logic [mcra_pkg::SAMPLE_BITS-1:0] out_value_r, out_value_nxt;
  logic                             out_last_r, out_last_nxt;

  // datapath registers of the current transaction
  logic [mcra_pkg::CH_BITS-1:0]     ch_r, ch_nxt;
  logic [mcra_pkg::SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic [mcra_pkg::LENGTH_BITS-1:0] cnt_r, cnt_nxt;
  logic [mcra_pkg::LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [mcra_pkg::ACC_BITS-1:0]    prod_r, prod_nxt;
  logic [mcra_pkg::ACC_BITS-1:0]    div_q_r, div_q_nxt;
  logic [mcra_pkg::LENGTH_BITS:0]   part_r, part_nxt;
  logic [mcra_pkg::STEP_BITS-1:0]   step_r, step_nxt;

  // state memory port
  logic                                ram_we, ram_re;
  logic [mcra_pkg::CH_BITS-1:0]        ram_raddr;
  logic [mcra_pkg::ENTRY_BITS-1:0]     ram_wdata, ram_rdata;
  mcra_pkg::entry_t                    wr_entry;

  // helpers
  logic                             in_fire;
  logic [mcra_pkg::USED_BITS-1:0]   used;
  logic [mcra_pkg::CH_BITS-1:0]     ptr_eff;
  mcra_pkg::entry_t                 cur_entry;
  mcra_pkg::entry_t                 rep_entry;
  logic [mcra_pkg::SLOT_BITS-1:0]   len_slot;
  logic [mcra_pkg::LENGTH_BITS-1:0] len;
  logic [mcra_pkg::LENGTH_BITS-1:0] cnt_new;
  logic [mcra_pkg::LENGTH_BITS:0]   part_sh;
  logic                             div_ge;
  logic [mcra_pkg::LENGTH_BITS:0]   round_sum;
  logic                             round_up;
  logic [mcra_pkg::ACC_BITS:0]      rounded;
  logic [mcra_pkg::SAMPLE_BITS-1:0] quot_sat;
  logic [mcra_pkg::SAMPLE_BITS-1:0] value_sat;
  logic [mcra_pkg::USED_BITS-1:0]   ptr_inc;
  logic [mcra_pkg::PERIOD_BITS-1:0] round_inc;
  logic                             later_hit;

  mcra_ram #(
    .WIDTH (mcra_pkg::ENTRY_BITS),
    .DEPTH (mcra_pkg::NUM_CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ch_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_wdata = wr_entry;

  // channel counts above the channel count act as the channel count
  assign used = (channels_used_r > mcra_pkg::USED_BITS'(mcra_pkg::NUM_CHANNELS)) ?
                mcra_pkg::USED_BITS'(mcra_pkg::NUM_CHANNELS) : channels_used_r;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;

  // stale pointer after the count was lowered restarts at channel 0
  assign ptr_eff = ({1'b0, ptr_r} >= used) ? '0 : ptr_r;

  // entries never written read as zero
  assign cur_entry = valid_r[ch_r] ? mcra_pkg::entry_t'(ram_rdata) : '0;
  assign rep_entry = valid_r[rep_ch_r[mcra_pkg::CH_BITS-1:0]] ?
                     mcra_pkg::entry_t'(ram_rdata) : '0;

  assign len_slot = filter_lengths_r[ch_r*mcra_pkg::SLOT_BITS +: mcra_pkg::SLOT_BITS];
  assign len      = mcra_pkg::LENGTH_BITS'(len_slot & mcra_pkg::LENGTH_MASK);

  // count ramps up to the filter length, a count above a shortened length is kept
  assign cnt_new = (cur_entry.cnt < len) ? cur_entry.cnt + 1'b1 : cur_entry.cnt;

  // restoring divide step, partial remainder stays below the count
  assign part_sh = {part_r[mcra_pkg::LENGTH_BITS-1:0], div_q_r[mcra_pkg::ACC_BITS-1]};
  assign div_ge  = (part_sh >= {1'b0, cnt_r});

  // rounded quotient is the quotient plus one when remainder + count/2 reaches count
  assign round_sum = {1'b0, part_r[mcra_pkg::LENGTH_BITS-1:0]} + {2'b00, cnt_r[mcra_pkg::LENGTH_BITS-1:1]};
  assign round_up  = (round_sum >= {1'b0, cnt_r});
  assign rounded   = {1'b0, div_q_r} + (mcra_pkg::ACC_BITS+1)'(round_up);

  assign quot_sat  = (div_q_r > mcra_pkg::ACC_BITS'(mcra_pkg::SAMPLE_MAX)) ?
                     mcra_pkg::SAMPLE_MAX : div_q_r[mcra_pkg::SAMPLE_BITS-1:0];
  assign value_sat = (rounded > (mcra_pkg::ACC_BITS+1)'(mcra_pkg::SAMPLE_MAX)) ?
                     mcra_pkg::SAMPLE_MAX : rounded[mcra_pkg::SAMPLE_BITS-1:0];

  assign ptr_inc   = {1'b0, ch_r} + 1'b1;
  assign round_inc = round_r + 1'b1;

  // any enabled active channel above the one being reported
  always_comb begin
    later_hit = 1'b0;
    for (int k = 0; k < mcra_pkg::NUM_CHANNELS; k++) begin
      if (report_mask_r[k] && (mcra_pkg::USED_BITS'(k) < used) &&
          (mcra_pkg::USED_BITS'(k) > rep_ch_r)) begin
        later_hit = 1'b1;
      end
    end
  end

  // configuration writes
  always_comb begin
    channels_used_nxt  = channels_used_r;
    filter_lengths_nxt = filter_lengths_r;
    report_mask_nxt    = report_mask_r;
    report_period_nxt  = report_period_r;
    if (cfg_we) begin
      case (mcra_pkg::cfg_reg_t'(cfg_addr))
        mcra_pkg::CFG_CHANNELS_USED:
          channels_used_nxt = cfg_wdata[mcra_pkg::USED_BITS-1:0];
        mcra_pkg::CFG_FILTER_LENGTHS:
          filter_lengths_nxt = cfg_wdata;
        mcra_pkg::CFG_REPORT_MASK:
          report_mask_nxt = cfg_wdata[mcra_pkg::MASK_BITS-1:0];
        mcra_pkg::CFG_REPORT_PERIOD:
          report_period_nxt = cfg_wdata[mcra_pkg::PERIOD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    ptr_nxt         = ptr_r;
    round_nxt       = round_r;
    valid_nxt       = valid_r;
    rep_ch_nxt      = rep_ch_r;
    out_valid_nxt   = out_valid_r;
    out_channel_nxt = out_channel_r;
    out_value_nxt   = out_value_r;
    out_last_nxt    = out_last_r;
    ch_nxt          = ch_r;
    sample_nxt      = sample_r;
    cnt_nxt         = cnt_r;
    rem_nxt         = rem_r;
    prod_nxt        = prod_r;
    div_q_nxt       = div_q_r;
    part_nxt        = part_r;
    step_nxt        = step_r;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_raddr       = ptr_eff;
    wr_entry        = cur_entry;

    // output transaction taken by the sink
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        // nothing happens while no channel is active
        if (in_fire && (used != '0)) begin
          ch_nxt     = ptr_eff;
          sample_nxt = in_chan.sample;
          if (in_chan.sample_present) begin
            ram_re    = 1'b1;
            state_nxt = S_READ;
          end else begin
            state_nxt = S_ADV;
          end
        end
      end

      S_READ: begin
        if (len > mcra_pkg::LENGTH_BITS'(1)) begin
          cnt_nxt   = cnt_new;
          rem_nxt   = cur_entry.rem;
          prod_nxt  = mcra_pkg::ACC_BITS'(cnt_new - 1'b1) *
                      mcra_pkg::ACC_BITS'(cur_entry.quot);
          state_nxt = S_ADD;
        end else begin
          // no averaging: keep the raw sample, leave average state alone
          wr_entry.latest = sample_r;
          ram_we          = 1'b1;
          valid_nxt[ch_r] = 1'b1;
          state_nxt       = S_ADV;
        end
      end

      S_ADD: begin
        div_q_nxt = mcra_pkg::ACC_BITS'(sample_r) + prod_r + mcra_pkg::ACC_BITS'(rem_r);
        part_nxt  = '0;
        step_nxt  = mcra_pkg::STEP_BITS'(mcra_pkg::ACC_BITS);
        state_nxt = S_DIV;
      end

      S_DIV: begin
        part_nxt  = div_ge ? part_sh - {1'b0, cnt_r} : part_sh;
        div_q_nxt = {div_q_r[mcra_pkg::ACC_BITS-2:0], div_ge};
        step_nxt  = step_r - 1'b1;
        if (step_r == mcra_pkg::STEP_BITS'(1)) begin
          state_nxt = S_WB;
        end
      end

      S_WB: begin
        wr_entry.latest = value_sat;
        wr_entry.quot   = quot_sat;
        wr_entry.rem    = part_r[mcra_pkg::LENGTH_BITS-1:0];
        wr_entry.cnt    = cnt_r;
        ram_we          = 1'b1;
        valid_nxt[ch_r] = 1'b1;
        state_nxt       = S_ADV;
      end

      S_ADV: begin
        if (ptr_inc < used) begin
          ptr_nxt   = ptr_inc[mcra_pkg::CH_BITS-1:0];
          state_nxt = S_IDLE;
        end else begin
          // round complete
          ptr_nxt = '0;
          if (round_inc < report_period_r) begin
            round_nxt = round_inc;
            state_nxt = S_IDLE;
          end else begin
            round_nxt  = '0;
            rep_ch_nxt = '0;
            state_nxt  = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        ram_raddr = rep_ch_r[mcra_pkg::CH_BITS-1:0];
        if (rep_ch_r >= used) begin
          state_nxt = S_IDLE;
        end else if (report_mask_r[rep_ch_r[mcra_pkg::CH_BITS-1:0]]) begin
          ram_re    = 1'b1;
          state_nxt = S_LOAD;
        end else begin
          rep_ch_nxt = rep_ch_r + 1'b1;
        end
      end

      S_LOAD: begin
        // read data holds in the memory output until the register is free
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt   = 1'b1;
          out_channel_nxt = rep_ch_r[mcra_pkg::CH_BITS-1:0];
          out_value_nxt   = rep_entry.latest;
          out_last_nxt    = !later_hit;
          rep_ch_nxt      = rep_ch_r + 1'b1;
          state_nxt       = later_hit ? S_SCAN : S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      channels_used_r  <= '0;
      filter_lengths_r <= '0;
      report_mask_r    <= '0;
      report_period_r  <= mcra_pkg::PERIOD_BITS'(1);
      ptr_r            <= '0;
      round_r          <= '0;
      valid_r          <= '0;
      rep_ch_r         <= '0;
      out_valid_r      <= 1'b0;
      out_channel_r    <= '0;
      out_value_r      <= '0;
      out_last_r       <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      channels_used_r  <= channels_used_nxt;
      filter_lengths_r <= filter_lengths_nxt;
      report_mask_r    <= report_mask_nxt;
      report_period_r  <= report_period_nxt;
      ptr_r            <= ptr_nxt;
      round_r          <= round_nxt;
      valid_r          <= valid_nxt;
      rep_ch_r         <= rep_ch_nxt;
      out_valid_r      <= out_valid_nxt;
      out_channel_r    <= out_channel_nxt;
      out_value_r      <= out_value_nxt;
      out_last_r       <= out_last_nxt;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    ch_r     <= ch_nxt;
    sample_r <= sample_nxt;
    cnt_r    <= cnt_nxt;
    rem_r    <= rem_nxt;
    prod_r   <= prod_nxt;
    div_q_r  <= div_q_nxt;
    part_r   <= part_nxt;
    step_r   <= step_nxt;
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.channel = out_channel_r;
  assign out_chan.value   = out_value_r;
  assign out_chan.last    = out_last_r;

endmodule

FILE: sv/mcra_ram.sv
// generic single-port-write, registered-read memory
`timescale 1ns / 1ps

module mcra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/mcra_checker.sv
// port-level assertions for the adc running average block and their bind
`timescale 1ns / 1ps

module mcra_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [mcra_pkg::CH_BITS-1:0]     out_channel,
  input logic [mcra_pkg::SAMPLE_BITS-1:0] out_value,
  input logic                             out_last
);

  logic                         run_open_r;
  logic [mcra_pkg::CH_BITS-1:0] prev_ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_open_r <= 1'b0;
      prev_ch_r  <= '0;
    end else if (out_valid && out_ready) begin
      run_open_r <= !out_last;
      prev_ch_r  <= out_channel;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_channel) &&
    $stable(out_value) && $stable(out_last))
    else $error("stalled result changed");

  // no new sample while a report run still has results to come
  a_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("sample taken during report run");

  // channels of one report run ascend
  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && run_open_r |-> out_channel > prev_ch_r)
    else $error("report channels out of order");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind multichannel_adc_running_average mcra_checker u_mcra_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_channel (out_chan.channel),
  .out_value   (out_chan.value),
  .out_last    (out_chan.last)
);

FILE: verif/tb.sv
// self-checking testbench for the multichannel adc running average block
`timescale 1ns / 1ps

module tb;
  import mcra_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE       = 64;
  localparam int RANDOM_ITEMS = 380;

  typedef struct packed {
    logic [CH_BITS-1:0]     channel;
    logic [SAMPLE_BITS-1:0] value;
    logic                   last;
  } report_t;

  // running-average predictor plus the queue of report transactions it expects
  class report_tracker;
    logic [USED_BITS-1:0]   used_reg;
    logic [CFG_BITS-1:0]    lengths_reg;
    logic [MASK_BITS-1:0]   mask_reg;
    logic [PERIOD_BITS-1:0] period_reg;
    logic [SAMPLE_BITS-1:0] latest [NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] quot [NUM_CHANNELS];
    logic [LENGTH_BITS-1:0] rem [NUM_CHANNELS];
    logic [LENGTH_BITS-1:0] cnt [NUM_CHANNELS];
    int unsigned            ptr;
    logic [PERIOD_BITS-1:0] rounds;
    report_t                expected_reports [$];
    int                     errors;

    function new();
      used_reg    = '0;
      lengths_reg = '0;
      mask_reg    = '0;
      period_reg  = PERIOD_BITS'(1);
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        latest[k] = '0;
        quot[k]   = '0;
        rem[k]    = '0;
        cnt[k]    = '0;
      end
      ptr    = 0;
      rounds = '0;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_BITS-1:0] data);
      case (idx)
        CFG_CHANNELS_USED:  used_reg = data[USED_BITS-1:0];
        CFG_FILTER_LENGTHS: lengths_reg = data;
        CFG_REPORT_MASK:    mask_reg = data[MASK_BITS-1:0];
        CFG_REPORT_PERIOD:  period_reg = data[PERIOD_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned active_channels();
      return (used_reg > NUM_CHANNELS) ? NUM_CHANNELS : used_reg;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    // cumulative average with carried remainder, or the raw sample for short filters
    function void absorb(int unsigned ch, logic [SAMPLE_BITS-1:0] s);
      int unsigned len, c, acc, q, r;
      len = lengths_reg[ch*SLOT_BITS +: SLOT_BITS] & LENGTH_MASK;
      if (len > 1) begin
        c = cnt[ch];
        if (c < len) begin
          c++;
          cnt[ch] = LENGTH_BITS'(c);
        end
        acc = s + (c - 1) * quot[ch] + rem[ch];
        q = acc / c;
        quot[ch] = (q > SAMPLE_MAX) ? SAMPLE_MAX : SAMPLE_BITS'(q);
        rem[ch] = LENGTH_BITS'(acc % c);
        r = (acc + c / 2) / c;
        latest[ch] = (r > SAMPLE_MAX) ? SAMPLE_MAX : SAMPLE_BITS'(r);
      end else begin
        latest[ch] = s;
      end
    endfunction

    function void note_sample(logic [SAMPLE_BITS-1:0] s, logic present);
      int unsigned used;
      int          last_ch;
      report_t     rpt;
      used = active_channels();
      if (used == 0) return;
      if (ptr >= used) ptr = 0;
      if (present) absorb(ptr, s);
      ptr++;
      if (ptr < used) return;
      ptr = 0;
      rounds = rounds + 1'b1;
      if (rounds < period_reg) return;
      rounds = '0;
      last_ch = -1;
      for (int ch = 0; ch < used; ch++)
        if (mask_reg[ch]) last_ch = ch;
      for (int ch = 0; ch < used; ch++) begin
        if (mask_reg[ch]) begin
          rpt.channel = CH_BITS'(ch);
          rpt.value   = latest[ch];
          rpt.last    = (ch == last_ch);
          expected_reports.push_back(rpt);
        end
      end
    endfunction

    function void check_report(logic [CH_BITS-1:0] ch, logic [SAMPLE_BITS-1:0] v, logic last);
      report_t exp_rpt;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report channel %0d value %h last %b", $time, ch, v, last);
        errors++;
        return;
      end
      exp_rpt = expected_reports.pop_front();
      if (ch !== exp_rpt.channel) begin
        $display("%0t: channel mismatch expected %0d actual %0d", $time, exp_rpt.channel, ch);
        errors++;
      end
      if (v !== exp_rpt.value) begin
        $display("%0t: value mismatch on channel %0d expected %h actual %h",
                 $time, exp_rpt.channel, exp_rpt.value, v);
        errors++;
      end
      if (last !== exp_rpt.last) begin
        $display("%0t: last mismatch on channel %0d expected %b actual %b",
                 $time, exp_rpt.channel, exp_rpt.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [ADDR_BITS-1:0] cfg_addr;
  logic [CFG_BITS-1:0]  cfg_wdata;
  int                   cycles = 0;
  bit                   in_steady;
  bit                   out_steady;
  report_tracker        tracker;

  mcra_in_if  in_bus ();
  mcra_out_if out_bus ();

  multichannel_adc_running_average DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_bus),
    .out_chan  (out_bus),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // config write; cfg_we stays high so back-to-back writes need no gap
  task automatic cfg_write(cfg_reg_t idx, logic [CFG_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic cfg_close();
    cfg_we <= 1'b0;
  endtask

  // one sample transaction; valid is only dropped when a gap is drawn
  task automatic send_sample(logic [SAMPLE_BITS-1:0] s, logic present);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.sample         <= s;
    in_bus.sample_present <= present;
    do @(posedge clk); while (!in_bus.ready);
    tracker.note_sample(s, present);
  endtask

  // wait for every expected report, then let the last sample finish inside the block
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // one random phase: fresh config (some registers left alone), then a burst of samples
  task automatic run_random_phase(inout int counted);
    logic [CFG_BITS-1:0] lengths;
    logic [SLOT_BITS-1:0] slot;
    int n_items;
    int pick;
    logic [SAMPLE_BITS-1:0] s;
    drain();
    in_steady  = ($urandom_range(0, 3) == 0);
    out_steady = ($urandom_range(0, 3) == 0);

    pick = $urandom_range(0, 19);
    if (pick == 0)
      cfg_write(CFG_CHANNELS_USED, '0);
    else if (pick < 4)
      cfg_write(CFG_CHANNELS_USED, CFG_BITS'($urandom_range(9, 15)));
    else
      cfg_write(CFG_CHANNELS_USED, CFG_BITS'($urandom_range(1, 8)));

    if ($urandom_range(0, 3) != 0) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) lengths = '0;
      else if (pick == 1) lengths = '1;
      else begin
        for (int k = 0; k < NUM_CHANNELS; k++) begin
          pick = $urandom_range(0, 19);
          if (pick < 5) slot = SLOT_BITS'($urandom_range(0, 1));
          else if (pick < 15) slot = SLOT_BITS'($urandom_range(2, 8));
          else if (pick < 18) slot = SLOT_BITS'($urandom_range(9, 254));
          else slot = '1;
          lengths[k*SLOT_BITS +: SLOT_BITS] = slot;
        end
      end
      cfg_write(CFG_FILTER_LENGTHS, lengths);
    end

    if ($urandom_range(0, 3) != 0) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) cfg_write(CFG_REPORT_MASK, '0);
      else if (pick == 1) cfg_write(CFG_REPORT_MASK, CFG_BITS'(8'hFF));
      else cfg_write(CFG_REPORT_MASK, CFG_BITS'($urandom_range(0, 255)));
    end

    if ($urandom_range(0, 2) != 0) begin
      pick = $urandom_range(0, 19);
      if (pick < 3) cfg_write(CFG_REPORT_PERIOD, '0);
      else if (pick == 3) cfg_write(CFG_REPORT_PERIOD, CFG_BITS'(16'hFFFF));
      else if (pick < 7) cfg_write(CFG_REPORT_PERIOD, CFG_BITS'($urandom_range(4, 10)));
      else cfg_write(CFG_REPORT_PERIOD, CFG_BITS'($urandom_range(1, 3)));
    end
    cfg_close();

    // with no active channel the samples are ignored, so keep that phase short
    n_items = (tracker.active_channels() == 0) ? 5 : $urandom_range(20, 60);
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) s = '0;
      else if (pick == 1) s = SAMPLE_MAX;
      else s = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
      send_sample(s, ($urandom_range(0, 6) != 0));
      if (tracker.active_channels() != 0) counted++;
    end
  endtask

  // report sink: random stall before each transaction, ready held while waiting
  initial begin
    int stall;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = out_steady ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      tracker.check_report(out_bus.channel, out_bus.value, out_bus.last);
    end
  end

  initial begin
    int counted;
    tracker = new();
    counted = 0;
    in_steady  = 1'b0;
    out_steady = 1'b0;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= CFG_CHANNELS_USED;
    cfg_wdata <= '0;
    in_bus.valid          <= 1'b0;
    in_bus.sample         <= '0;
    in_bus.sample_present <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no channels after reset: the transaction is swallowed
    send_sample(12'hABC, 1'b1);
    drain();

    // three channels: raw, length one (also raw), length three; zero period reports each round
    cfg_write(CFG_CHANNELS_USED, CFG_BITS'(3));
    cfg_write(CFG_FILTER_LENGTHS, 64'hFFFF_FFFF_FF03_0100);
    cfg_write(CFG_REPORT_MASK, CFG_BITS'(8'hFF));
    cfg_write(CFG_REPORT_PERIOD, '0);
    cfg_close();
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample('0, 1'b1);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample('0, 1'b1);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(12'hFFE, 1'b1);
    // empty reads leave the channel value untouched
    send_sample(12'h123, 1'b0);
    send_sample('0, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);

    // leave the pointer mid-round, then shrink to one channel so it restarts
    drain();
    send_sample(12'h555, 1'b1);
    drain();
    cfg_write(CFG_CHANNELS_USED, CFG_BITS'(1));
    cfg_write(CFG_REPORT_PERIOD, CFG_BITS'(50));
    cfg_close();
    send_sample(12'h001, 1'b1);
    send_sample(12'h800, 1'b1);
    send_sample(12'h7FF, 1'b1);

    // period drops below the round count: the next round reports
    drain();
    cfg_write(CFG_REPORT_PERIOD, CFG_BITS'(2));
    cfg_close();
    send_sample(12'hAAA, 1'b1);

    // channel two's filter shortened below its count; mask selects only an idle channel
    drain();
    cfg_write(CFG_CHANNELS_USED, CFG_BITS'(3));
    cfg_write(CFG_FILTER_LENGTHS, 64'hFFFF_FFFF_FF02_0100);
    cfg_write(CFG_REPORT_MASK, CFG_BITS'(8'h08));
    cfg_write(CFG_REPORT_PERIOD, CFG_BITS'(1));
    cfg_close();
    send_sample(12'h0F0, 1'b1);
    send_sample(12'hF0F, 1'b1);
    send_sample(12'hFA0, 1'b1);

    // channel count above eight acts as eight, longest filters everywhere
    drain();
    cfg_write(CFG_CHANNELS_USED, CFG_BITS'(15));
    cfg_write(CFG_FILTER_LENGTHS, '1);
    cfg_write(CFG_REPORT_MASK, CFG_BITS'(8'hFF));
    cfg_close();
    for (int k = 0; k < NUM_CHANNELS; k++)
      send_sample((k % 2 == 0) ? SAMPLE_MAX : SAMPLE_BITS'(k), 1'b1);

    // random phases until enough transactions reached an active block
    while (counted < RANDOM_ITEMS) run_random_phase(counted);

    drain();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/mcra_pkg.sv
sv/mcra_if.sv
sv/mcra_ram.sv
sv/multichannel_adc_running_average.sv
sv/mcra_checker.sv
verif/tb.sv
